### hw/rtl/prs_pkg.sv
// Shared types, constants and helper functions for the power/reset sequencer.
package prs_pkg;

    localparam int MAX_RAILS  = 8;
    localparam int MAX_RESETS = 8;

    localparam int RAIL_W  = 8;
    localparam int RST_W   = 8;
    localparam int COUNT_W = 4;
    localparam int MON_W   = 3;
    localparam int CFG_W   = 8;

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_POWER_ON  = 2'd1,
        REQ_POWER_OFF = 2'd2,
        REQ_IGNORED   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_NUM_RAILS     = 2'd0,
        CFG_NUM_RESETS    = 2'd1,
        CFG_CRITICAL_MASK = 2'd2,
        CFG_SUPPLY_MASK   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [RAIL_W-1:0]  rail_on;
        logic [RST_W-1:0]   reset_held;
        logic               power_flag;
        logic               done_flag;
        logic [COUNT_W-1:0] stage_index;
        logic [MON_W-1:0]   monitor_index;
    } seq_state_t;

    typedef struct packed {
        logic panic;
        logic lost;
        logic complete;
        logic rollback;
    } seq_events_t;

    // Zero counts as one, anything above the maximum is clamped.
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] v,
                                                     input logic [COUNT_W-1:0] max_v);
        logic [COUNT_W-1:0] r;
        if (v == '0) begin
            r = COUNT_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Mask of the low n bits, n in 0..8.
    function automatic logic [RST_W-1:0] low_mask(input logic [COUNT_W-1:0] n);
        logic [RST_W-1:0] m;
        for (int i = 0; i < RST_W; i++) begin
            m[i] = (COUNT_W'(i) < n);
        end
        return m;
    endfunction

endpackage

### hw/rtl/power_reset_sequencer_core.sv
// Power rail and staged reset-chain sequencer with round-robin rail monitor.
// Datapath: an accepted transaction is captured in the input register, then one pass
// of logic writes its result into the result register.
// One transaction per cycle unless m_ready stalls the result register; the whole step
// is one combinational pass from the input register and the state registers.
// Reset: aresetn synchronous, active low; rails off, all resets held, config at defaults.
module power_reset_sequencer_core
    import prs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    // configuration write port
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,

    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [RST_W-1:0]  s_reset_ready,
    input  logic [RAIL_W-1:0] s_rail_power_good,
    input  logic [RAIL_W-1:0] s_rail_came_up,

    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [RAIL_W-1:0]  m_rail_enables,
    output logic [RST_W-1:0]   m_reset_asserts,
    output logic               m_powered,
    output logic               m_chain_done,
    output logic [COUNT_W-1:0] m_reset_stage,
    output logic               m_panic_event,
    output logic               m_power_lost_event,
    output logic               m_chain_complete_event,
    output logic               m_rollback_event
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] num_rails_reg;
    logic [COUNT_W-1:0] num_resets_reg;
    logic [RAIL_W-1:0]  critical_mask_reg;
    logic [RAIL_W-1:0]  supply_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rails_reg     <= COUNT_W'(1);
            num_resets_reg    <= COUNT_W'(1);
            critical_mask_reg <= '0;
            supply_mask_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NUM_RAILS:     num_rails_reg     <= cfg_wdata[COUNT_W-1:0];
                CFG_NUM_RESETS:    num_resets_reg    <= cfg_wdata[COUNT_W-1:0];
                CFG_CRITICAL_MASK: critical_mask_reg <= cfg_wdata[RAIL_W-1:0];
                CFG_SUPPLY_MASK:   supply_mask_reg   <= cfg_wdata[RAIL_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic              in_valid_reg;
    logic [1:0]        in_req_reg;
    logic [RST_W-1:0]  in_ready_bits_reg;
    logic [RAIL_W-1:0] in_good_reg;
    logic [RAIL_W-1:0] in_came_reg;

    logic out_free;   // result register can take a new transaction
    logic advance;    // held transaction is processed this cycle

    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg        <= s_req_type;
            in_ready_bits_reg <= s_reset_ready;
            in_good_reg       <= s_rail_power_good;
            in_came_reg       <= s_rail_came_up;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and step logic
    // ------------------------------------------------------------------
    seq_state_t  state_reg, state_next;
    seq_events_t ev_next;

    logic [COUNT_W-1:0] n_rails;
    logic [COUNT_W-1:0] n_resets;
    logic [RAIL_W-1:0]  rail_mask;
    logic [RST_W-1:0]   reset_mask;

    assign n_rails    = eff_count(num_rails_reg, COUNT_W'(MAX_RAILS));
    assign n_resets   = eff_count(num_resets_reg, COUNT_W'(MAX_RESETS));
    assign rail_mask  = low_mask(n_rails);
    assign reset_mask = low_mask(n_resets);

    always_comb begin
        seq_state_t         st;
        seq_events_t        ev;
        logic [COUNT_W-1:0] s_inc;
        logic [RST_W-1:0]   below;      // stages under current stage and count
        logic [RST_W-1:0]   miss;       // of those, stages not ready
        logic [RST_W-1:0]   upto_miss;  // mask through lowest missing stage
        logic [COUNT_W-1:0] miss_idx;
        logic [MON_W-1:0]   mon;
        logic [COUNT_W-1:0] mon_inc;
        logic               fail;

        st        = state_reg;
        ev        = '0;
        s_inc     = '0;
        below     = '0;
        miss      = '0;
        upto_miss = '0;
        miss_idx  = '0;
        mon       = '0;
        mon_inc   = '0;
        fail      = 1'b0;

        case (req_t'(in_req_reg))
            REQ_TICK: begin
                // reset chain: advance
                if (!st.done_flag) begin
                    if (st.stage_index >= n_resets) begin
                        st.stage_index = n_resets;
                        st.done_flag   = 1'b1;
                        ev.complete    = 1'b1;
                    end else if (in_ready_bits_reg[st.stage_index[MON_W-1:0]]) begin
                        s_inc          = st.stage_index + COUNT_W'(1);
                        st.stage_index = s_inc;
                        if (s_inc >= n_resets) begin
                            st.done_flag = 1'b1;
                            ev.complete  = 1'b1;
                        end else begin
                            st.reset_held[s_inc[MON_W-1:0]] = 1'b0;
                        end
                    end
                end
                // reset chain: roll back to lowest stage that lost ready
                below = low_mask(st.stage_index) & reset_mask;
                miss  = below & ~in_ready_bits_reg;
                if (miss != '0) begin
                    upto_miss = miss ^ (miss - RST_W'(1));
                    for (int i = RST_W - 1; i >= 0; i--) begin
                        if (miss[i]) begin
                            miss_idx = COUNT_W'(i);
                        end
                    end
                    st.stage_index = miss_idx;
                    st.done_flag   = 1'b0;
                    st.reset_held  = st.reset_held | (reset_mask & ~upto_miss);
                    ev.rollback    = 1'b1;
                end
                // rail monitor
                mon = (COUNT_W'(st.monitor_index) < n_rails) ? st.monitor_index : '0;
                if (!in_good_reg[mon]) begin
                    if (critical_mask_reg[mon]) begin
                        fail     = 1'b1;
                        ev.panic = 1'b1;
                    end else if (supply_mask_reg[mon]) begin
                        fail    = 1'b1;
                        ev.lost = 1'b1;
                    end
                end
                mon_inc = COUNT_W'(mon) + COUNT_W'(1);
                st.monitor_index = (mon_inc == n_rails) ? '0 : mon_inc[MON_W-1:0];
            end
            REQ_POWER_ON: begin
                if ((in_came_reg | ~rail_mask) != '1) begin
                    fail     = 1'b1;
                    ev.panic = 1'b1;
                end else begin
                    st.rail_on       = rail_mask;
                    st.power_flag    = 1'b1;
                    st.done_flag     = 1'b0;
                    st.stage_index   = '0;
                    st.reset_held[0] = 1'b0;
                end
            end
            REQ_POWER_OFF: begin
                fail = 1'b1;
            end
            default: ;
        endcase

        // panic / power lost / power-off: everything down
        if (fail) begin
            st.rail_on     = '0;
            st.reset_held  = '1;
            st.power_flag  = 1'b0;
            st.done_flag   = 1'b0;
            st.stage_index = '0;
        end

        state_next = st;
        ev_next    = ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.rail_on       <= '0;
            state_reg.reset_held    <= '1;
            state_reg.power_flag    <= 1'b0;
            state_reg.done_flag     <= 1'b0;
            state_reg.stage_index   <= '0;
            state_reg.monitor_index <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        out_valid_reg;
    seq_state_t  out_state_reg;
    seq_events_t out_ev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_state_reg <= state_next;
            out_ev_reg    <= ev_next;
        end
    end

    assign m_valid                = out_valid_reg;
    assign m_rail_enables         = out_state_reg.rail_on;
    assign m_reset_asserts        = out_state_reg.reset_held;
    assign m_powered              = out_state_reg.power_flag;
    assign m_chain_done           = out_state_reg.done_flag;
    assign m_reset_stage          = out_state_reg.stage_index;
    assign m_panic_event          = out_ev_reg.panic;
    assign m_power_lost_event     = out_ev_reg.lost;
    assign m_chain_complete_event = out_ev_reg.complete;
    assign m_rollback_event       = out_ev_reg.rollback;

endmodule

### bench/prs_checker.sv
// Scoreboard for the power/reset sequencer: predicts each status transaction and compares it.
`timescale 1ns / 100ps

module prs_checker
    import prs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [RST_W-1:0]   s_reset_ready,
    input  logic [RAIL_W-1:0]  s_rail_power_good,
    input  logic [RAIL_W-1:0]  s_rail_came_up,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [RAIL_W-1:0]  m_rail_enables,
    input  logic [RST_W-1:0]   m_reset_asserts,
    input  logic               m_powered,
    input  logic               m_chain_done,
    input  logic [COUNT_W-1:0] m_reset_stage,
    input  logic               m_panic_event,
    input  logic               m_power_lost_event,
    input  logic               m_chain_complete_event,
    input  logic               m_rollback_event,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic [RAIL_W-1:0]  rail_en;
        logic [RST_W-1:0]   rst_held;
        logic               powered;
        logic               chain_done;
        logic [COUNT_W-1:0] stage;
        logic               panic;
        logic               lost;
        logic               complete;
        logic               rollback;
    } status_t;

    // shadow registers
    logic [3:0]         rails_cfg;
    logic [3:0]         resets_cfg;
    logic [7:0]         crit_cfg;
    logic [7:0]         supply_cfg;

    // shadow sequencer state
    logic [RAIL_W-1:0]  rails_q;
    logic [RST_W-1:0]   held_q;
    logic               power_q;
    logic               done_q;
    logic [COUNT_W-1:0] stage_q;
    logic [MON_W-1:0]   mon_q;

    status_t            expected_status[$];
    int                 results_seen;

    // 0 acts as 1, anything above 8 acts as 8
    function automatic int usable_count(input logic [3:0] v);
        int r;
        r = (v == 4'd0) ? 1 : ((v > 4'd8) ? 8 : int'(v));
        return r;
    endfunction

    function automatic logic [7:0] ones_below(input int n);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = (i < n);
        end
        return m;
    endfunction

    task automatic shut_down();
        rails_q = '0;
        held_q  = '1;
        power_q = 1'b0;
        done_q  = 1'b0;
        stage_q = '0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch on status %0d: %s got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
    endtask

    // One request step: chain and monitor on a tick, rail enable and chain start on power-on, shutdown on power-off.
    task automatic sequence_step(input req_t rq, input logic [7:0] ready,
                                 input logic [7:0] good, input logic [7:0] came,
                                 output status_t res);
        int   n_rst;
        int   n_rail;
        int   idx;
        int   i;
        bit   hit;
        logic ev_panic, ev_lost, ev_done, ev_back;
        n_rst    = usable_count(resets_cfg);
        n_rail   = usable_count(rails_cfg);
        ev_panic = 1'b0;
        ev_lost  = 1'b0;
        ev_done  = 1'b0;
        ev_back  = 1'b0;
        hit      = 1'b0;
        case (rq)
            REQ_TICK: begin
                if (!done_q) begin
                    if (stage_q >= n_rst) begin
                        // count shrank under the chain
                        stage_q = COUNT_W'(n_rst);
                        done_q  = 1'b1;
                        ev_done = 1'b1;
                    end else if (ready[stage_q]) begin
                        stage_q++;
                        if (stage_q >= n_rst) begin
                            done_q  = 1'b1;
                            ev_done = 1'b1;
                        end else begin
                            held_q[stage_q] = 1'b0;
                        end
                    end
                end
                // lowest earlier stage that dropped ready pulls the chain back
                for (i = 0; i < 8; i++) begin
                    if (!hit && i < stage_q && i < n_rst && !ready[i]) begin
                        stage_q = COUNT_W'(i);
                        done_q  = 1'b0;
                        held_q  = held_q | (ones_below(n_rst) & ~ones_below(i + 1));
                        ev_back = 1'b1;
                        hit     = 1'b1;
                    end
                end
                idx = (mon_q < n_rail) ? int'(mon_q) : 0;
                if (!good[idx]) begin
                    if (crit_cfg[idx]) begin
                        shut_down();
                        ev_panic = 1'b1;
                    end else if (supply_cfg[idx]) begin
                        shut_down();
                        ev_lost = 1'b1;
                    end
                end
                mon_q = MON_W'((idx + 1) % n_rail);
            end
            REQ_POWER_ON: begin
                if ((came & ones_below(n_rail)) != ones_below(n_rail)) begin
                    shut_down();
                    ev_panic = 1'b1;
                end else begin
                    rails_q   = ones_below(n_rail);
                    power_q   = 1'b1;
                    done_q    = 1'b0;
                    stage_q   = '0;
                    held_q[0] = 1'b0;
                end
            end
            REQ_POWER_OFF: shut_down();
            default: ;
        endcase
        res.rail_en    = rails_q;
        res.rst_held   = held_q;
        res.powered    = power_q;
        res.chain_done = done_q;
        res.stage      = stage_q;
        res.panic      = ev_panic;
        res.lost       = ev_lost;
        res.complete   = ev_done;
        res.rollback   = ev_back;
    endtask

    always @(posedge aclk) begin : observe
        status_t got;
        status_t want;
        if (!aresetn) begin
            rails_cfg   = 4'd1;
            resets_cfg  = 4'd1;
            crit_cfg    = '0;
            supply_cfg  = '0;
            shut_down();
            mon_q       = '0;
            expected_status.delete();
            mismatches  = 0;
            outstanding = 0;
            results_seen = 0;
        end else begin
            // compare first: a status can never belong to a request accepted this edge
            if (m_valid && m_ready) begin
                got.rail_en    = m_rail_enables;
                got.rst_held   = m_reset_asserts;
                got.powered    = m_powered;
                got.chain_done = m_chain_done;
                got.stage      = m_reset_stage;
                got.panic      = m_panic_event;
                got.lost       = m_power_lost_event;
                got.complete   = m_chain_complete_event;
                got.rollback   = m_rollback_event;
                if (expected_status.size() == 0) begin
                    report_mismatch("status with no request pending", 1, 0);
                end else begin
                    want = expected_status.pop_front();
                    if (got.rail_en !== want.rail_en)
                        report_mismatch("rail_enables", got.rail_en, want.rail_en);
                    if (got.rst_held !== want.rst_held)
                        report_mismatch("reset_asserts", got.rst_held, want.rst_held);
                    if (got.powered !== want.powered)
                        report_mismatch("powered", got.powered, want.powered);
                    if (got.chain_done !== want.chain_done)
                        report_mismatch("chain_done", got.chain_done, want.chain_done);
                    if (got.stage !== want.stage)
                        report_mismatch("reset_stage", got.stage, want.stage);
                    if (got.panic !== want.panic)
                        report_mismatch("panic_event", got.panic, want.panic);
                    if (got.lost !== want.lost)
                        report_mismatch("power_lost_event", got.lost, want.lost);
                    if (got.complete !== want.complete)
                        report_mismatch("chain_complete_event", got.complete, want.complete);
                    if (got.rollback !== want.rollback)
                        report_mismatch("rollback_event", got.rollback, want.rollback);
                end
                results_seen++;
            end
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_NUM_RAILS:     rails_cfg  = cfg_wdata[3:0];
                    CFG_NUM_RESETS:    resets_cfg = cfg_wdata[3:0];
                    CFG_CRITICAL_MASK: crit_cfg   = cfg_wdata;
                    CFG_SUPPLY_MASK:   supply_cfg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                sequence_step(req_t'(s_req_type), s_reset_ready, s_rail_power_good,
                              s_rail_came_up, want);
                expected_status.push_back(want);
            end
            outstanding = expected_status.size();
        end
    end

endmodule

### bench/tb_top.sv
// Top-level bench for the power/reset sequencer: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb_top;
    import prs_pkg::*;

    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_OFF    = 120;   // long receiver stall, in cycles
    localparam int QUIET_LIMIT = 2000;  // cycles with no transaction before giving up
    localparam int TAIL_CYCLES = 8;     // margin after the last transaction

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_req_type;
    logic [RST_W-1:0]   s_reset_ready;
    logic [RAIL_W-1:0]  s_rail_power_good;
    logic [RAIL_W-1:0]  s_rail_came_up;
    logic               m_valid;
    logic               m_ready;
    logic [RAIL_W-1:0]  m_rail_enables;
    logic [RST_W-1:0]   m_reset_asserts;
    logic               m_powered;
    logic               m_chain_done;
    logic [COUNT_W-1:0] m_reset_stage;
    logic               m_panic_event;
    logic               m_power_lost_event;
    logic               m_chain_complete_event;
    logic               m_rollback_event;

    int mismatches;
    int outstanding;
    int quiet_cycles;

    // Pacing knobs for the request driver (src_idle) and the status sink (sink_idle, sink_hold_req).
    bit src_idle;
    bit sink_idle;
    bit sink_hold_req;

    power_reset_sequencer_core dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_wdata              (cfg_wdata),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_req_type             (s_req_type),
        .s_reset_ready          (s_reset_ready),
        .s_rail_power_good      (s_rail_power_good),
        .s_rail_came_up         (s_rail_came_up),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_rail_enables         (m_rail_enables),
        .m_reset_asserts        (m_reset_asserts),
        .m_powered              (m_powered),
        .m_chain_done           (m_chain_done),
        .m_reset_stage          (m_reset_stage),
        .m_panic_event          (m_panic_event),
        .m_power_lost_event     (m_power_lost_event),
        .m_chain_complete_event (m_chain_complete_event),
        .m_rollback_event       (m_rollback_event)
    );

    prs_checker u_checker (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_wdata              (cfg_wdata),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_req_type             (s_req_type),
        .s_reset_ready          (s_reset_ready),
        .s_rail_power_good      (s_rail_power_good),
        .s_rail_came_up         (s_rail_came_up),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_rail_enables         (m_rail_enables),
        .m_reset_asserts        (m_reset_asserts),
        .m_powered              (m_powered),
        .m_chain_done           (m_chain_done),
        .m_reset_stage          (m_reset_stage),
        .m_panic_event          (m_panic_event),
        .m_power_lost_event     (m_power_lost_event),
        .m_chain_complete_event (m_chain_complete_event),
        .m_rollback_event       (m_rollback_event),
        .mismatches             (mismatches),
        .outstanding            (outstanding)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog: any transaction on either channel, or a register write, restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        quiet_cycles = 0;
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Status sink. Random stall bursts while sink_idle is set; a hold request
    // parks m_ready low while the HOLD_OFF wait runs, so the pipe backs up into s_ready.
    initial begin : status_sink
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge aclk);
                m_ready <= 1'b1;
                sink_hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Present one request and hold it until the transaction completes.
    // An optional idle burst goes in front of it.
    task automatic offer_request(input req_t rq, input logic [7:0] rdy,
                                 input logic [7:0] good, input logic [7:0] came);
        int gap;
        gap = 0;
        if (src_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_req_type        <= rq;
        s_reset_ready     <= rdy;
        s_rail_power_good <= good;
        s_rail_came_up    <= came;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic end_offer();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Sender pause: nothing goes in until every predicted status has come back.
    task automatic wait_for_results();
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_regs(input logic [7:0] rails, input logic [7:0] resets,
                                input logic [7:0] crit, input logic [7:0] supply);
        write_reg(CFG_NUM_RAILS, rails);
        write_reg(CFG_NUM_RESETS, resets);
        write_reg(CFG_CRITICAL_MASK, crit);
        write_reg(CFG_SUPPLY_MASK, supply);
    endtask

    initial begin : stimulus
        int   p;
        int   k;
        int   pick;
        req_t rq;
        logic [7:0] rdy;
        logic [7:0] good;
        logic [7:0] came;

        aresetn           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = CFG_NUM_RAILS;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_req_type        = REQ_TICK;
        s_reset_ready     = '0;
        s_rail_power_good = '0;
        s_rail_came_up    = '0;
        src_idle          = 1'b0;
        sink_idle         = 1'b0;
        sink_hold_req     = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---------------- directed part ----------------
        // 4 rails, 3 reset stages, rail 0 critical, rail 1 is the input supply
        program_regs(8'd4, 8'd3, 8'h01, 8'h02);
        // tick while unpowered: stage 0 not ready, monitor sees rail 0 bad -> panic
        offer_request(REQ_TICK, 8'h00, 8'h00, 8'h00);
        // reserved request code does nothing
        offer_request(REQ_IGNORED, 8'hFF, 8'hFF, 8'hFF);
        // rail 3 fails to come up -> panic shutdown
        offer_request(REQ_POWER_ON, 8'hFF, 8'hFF, 8'h07);
        offer_request(REQ_POWER_ON, 8'hFF, 8'hFF, 8'hFF);
        // walk the chain to completion, then one tick with the chain already done
        repeat (4) offer_request(REQ_TICK, 8'hFF, 8'hFF, 8'h00);
        // stage 1 drops ready -> rollback, later resets held again
        offer_request(REQ_TICK, 8'hFD, 8'hFF, 8'h00);
        offer_request(REQ_TICK, 8'hFF, 8'hFF, 8'h00);
        // supply rail bad; the monitor reaches rail 1 on the third tick -> power lost
        repeat (3) offer_request(REQ_TICK, 8'hFF, 8'hFD, 8'h00);
        offer_request(REQ_POWER_ON, 8'h00, 8'h00, 8'h0F);
        // critical rail bad; reached on the third tick -> panic
        repeat (3) offer_request(REQ_TICK, 8'hFF, 8'hFE, 8'h00);
        offer_request(REQ_POWER_OFF, 8'hFF, 8'hFF, 8'hFF);
        end_offer();
        wait_for_results();

        // stage left beyond the count after shrinking num_resets
        program_regs(8'd8, 8'd8, 8'h00, 8'h00);
        offer_request(REQ_POWER_ON, 8'h00, 8'hFF, 8'hFF);
        repeat (5) offer_request(REQ_TICK, 8'hFF, 8'hFF, 8'h00);
        end_offer();
        wait_for_results();
        write_reg(CFG_NUM_RESETS, 8'd2);
        offer_request(REQ_TICK, 8'hFF, 8'hFF, 8'h00);
        // nothing ready -> rollback to stage 0
        offer_request(REQ_TICK, 8'h00, 8'hFF, 8'h00);
        end_offer();
        wait_for_results();

        // ---------------- random part ----------------
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: program_regs(8'd1, 8'd1, 8'h00, 8'h00);
                1: program_regs(8'd8, 8'd8, 8'hFF, 8'hFF);
                2: program_regs(8'd0, 8'd0, 8'($urandom), 8'($urandom));   // zero acts as one
                3: program_regs(8'd15, 8'd15, 8'($urandom), 8'($urandom)); // clamped to eight
                4: program_regs(8'd8, 8'd8, 8'h00, 8'hFF);
                default: program_regs(8'($urandom_range(0, 9)), 8'($urandom_range(0, 9)),
                                      8'($urandom), 8'($urandom));
            endcase
            // some phases run with no idling at all; the last one always does
            pick      = $urandom_range(0, 3);
            src_idle  = (p != NUM_PHASES - 1) && (pick != 0) && (pick != 1);
            sink_idle = (p != NUM_PHASES - 1) && (pick != 0) && (pick != 2);
            if (p != NUM_PHASES - 1 && pick == 3) begin
                src_idle  = 1'b1;
                sink_idle = 1'b1;
            end

            for (k = 0; k < PHASE_ITEMS; k++) begin
                // back the pipe up once while requests keep coming
                if (p == 3 && k == 40) begin
                    sink_hold_req = 1'b1;
                end
                // mostly ticks with healthy inputs, some power-ons;
                // occasional dropped ready/power-good bits, power-offs and noise
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    rq = REQ_POWER_ON;
                end else if (pick < 9) begin
                    rq = REQ_POWER_OFF;
                end else if (pick < 11) begin
                    rq = REQ_IGNORED;
                end else begin
                    rq = REQ_TICK;
                end

                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    rdy = 8'hFF;
                end else if (pick < 9) begin
                    rdy = ~(8'h01 << $urandom_range(0, 7));
                end else begin
                    rdy = 8'($urandom);
                end

                pick = $urandom_range(0, 19);
                if (pick < 17) begin
                    good = 8'hFF;
                end else if (pick < 19) begin
                    good = ~(8'h01 << $urandom_range(0, 7));
                end else begin
                    good = 8'($urandom);
                end

                came = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'hFF;
                offer_request(rq, rdy, good, came);
            end
            end_offer();
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### power_reset_sequencer_core.f
hw/rtl/prs_pkg.sv
hw/rtl/power_reset_sequencer_core.sv
bench/prs_checker.sv
bench/tb_top.sv
